// ===== hw/rtl/tsw_pkg.sv =====
// Shared types, constants and helpers for the text scrollback window.
// No dependencies; every other file in this block imports it.
package tsw_pkg;

  localparam int LINE_WIDTH     = 20;
  localparam int SCREEN_ROWS    = 10;
  localparam int HISTORY_LINES  = 64;
  localparam int CELLS_PER_LINE = LINE_WIDTH + 1;
  localparam int STORE_CELLS    = HISTORY_LINES * CELLS_PER_LINE;

  localparam int LINE_W = 6;   // ring index, fixed by window_first_line
  localparam int ROW_W  = 4;   // window row
  localparam int COL_W  = 5;   // column, holds up to LINE_WIDTH+1
  localparam int ADDR_W = $clog2(STORE_CELLS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_UP     = 3'd1;
  localparam logic [2:0] CMD_DOWN   = 3'd2;
  localparam logic [2:0] CMD_FIRST  = 3'd3;
  localparam logic [2:0] CMD_LAST   = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  typedef logic [LINE_W-1:0] line_t;
  typedef logic [LINE_W:0]   line_ext_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [3:0] read_row;
    logic [4:0] read_column;
  } tsw_in_t;

  typedef struct packed {
    logic       draw_valid;
    logic [3:0] draw_row;
    logic [4:0] draw_column;
    logic [7:0] draw_char;
    logic       refresh;
    logic [7:0] read_char;
    logic [5:0] window_first_line;
    logic [3:0] window_rows;
  } tsw_out_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } tsw_op_kind_t;

  // One classified item on its way to the store side
  typedef struct packed {
    tsw_op_kind_t kind;
    addr_t        addr;
    logic [7:0]   wdata;
    tsw_out_t     res;
  } tsw_op_t;

  // (a + b) mod HISTORY_LINES, both below HISTORY_LINES
  function automatic line_t line_add(input line_t a, input line_ext_t b);
    line_ext_t sum;
    begin
      sum = line_ext_t'(a) + b;
      if (sum >= line_ext_t'(HISTORY_LINES)) begin
        sum = sum - line_ext_t'(HISTORY_LINES);
      end
      line_add = sum[LINE_W-1:0];
    end
  endfunction

  // (a - b) mod HISTORY_LINES, both below HISTORY_LINES
  function automatic line_t line_sub(input line_t a, input line_ext_t b);
    line_ext_t diff;
    begin
      if (line_ext_t'(a) >= b) begin
        diff = line_ext_t'(a) - b;
      end else begin
        diff = line_ext_t'(a) + line_ext_t'(HISTORY_LINES) - b;
      end
      line_sub = diff[LINE_W-1:0];
    end
  endfunction

  function automatic addr_t cell_addr(input line_t line, input logic [COL_W-1:0] col);
    begin
      cell_addr = addr_t'(line) * addr_t'(CELLS_PER_LINE) + addr_t'(col);
    end
  endfunction

endpackage

// ===== hw/rtl/text_scrollback_window.sv =====
// Top level of the text scrollback window: front end, operation queue and
// back end with the character store. Depends on tsw_pkg and the tsw_* modules.
//
// Text console scrollback. A ring of 64 lines of 20 characters (plus a
// terminator cell each) holds the history; a window of up to 10 rows follows
// the newest line. Both sides look like a queue: push a command beat while
// in_full is low, pop one result beat while out_empty is low. Every input beat
// gives exactly one result beat, in order. After reset the store is swept to
// zero, one cell per cycle, over all 1344 cells; in_full stays high during the
// sweep. The front end takes one beat per cycle while in_full is low and
// updates the line and window state at once; a 4-entry queue feeds the back
// end, whose cost sets the sustained rate: a character append adds a
// terminator write on the single store write port, an in-window read waits
// for the registered store read, and moves, newlines and out-of-window reads
// add no extra step. Bursts up to the queue depth are absorbed at one beat per cycle.
module text_scrollback_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  tsw_pkg::tsw_in_t  in_data,
  output logic              in_full,
  input  logic              out_pop,
  output tsw_pkg::tsw_out_t out_data,
  output logic              out_empty
);
  import tsw_pkg::*;

  logic    clearing;
  logic    q_full;
  logic    q_push;
  tsw_op_t q_push_op;
  logic    q_pop;
  tsw_op_t q_pop_op;
  logic    q_empty;

  // classify beats, hold scroll state
  tsw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_push_op)
  );

  // decouples the front from store stalls
  tsw_op_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (q_pop_op),
    .empty   (q_empty)
  );

  // store access and result register
  tsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_op      (q_pop_op),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/tsw_front.sv =====
// Front end: takes input beats, keeps the line and window state, classifies
// each beat into a store operation plus its result. Depends on tsw_pkg.
module tsw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  tsw_pkg::tsw_in_t in_data,
  output logic             in_full,
  input  logic             clearing,
  input  logic             q_full,
  output logic             q_push,
  output tsw_pkg::tsw_op_t q_op
);
  import tsw_pkg::*;

  line_t             oldest_r, oldest_nxt;
  line_t             count_r, count_nxt;
  logic [COL_W-1:0]  wcol_r, wcol_nxt;
  line_t             top_r, top_nxt;
  logic [ROW_W-1:0]  rows_r, rows_nxt;

  line_t newest;
  line_t bottom;
  logic  accept;

  assign in_full = q_full || clearing;
  assign accept  = in_push && !in_full;
  assign q_push  = accept;
  assign newest  = line_add(oldest_r, line_ext_t'(count_r));
  assign bottom  = line_add(top_r, line_ext_t'(rows_r));

  always_comb begin
    logic [COL_W-1:0] col_a;
    line_t            line_w;
    logic             refresh;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    wcol_nxt   = wcol_r;
    top_nxt    = top_r;
    rows_nxt   = rows_r;
    refresh    = 1'b0;
    col_a      = wcol_r;
    line_w     = '0;
    q_op       = '0;
    q_op.kind  = OP_NONE;
    unique case (in_data.command)
      CMD_APPEND: begin
        if (wcol_r >= COL_W'(LINE_WIDTH)) begin
          col_a = '0;
          if (count_r == line_t'(HISTORY_LINES - 1)) begin
            oldest_nxt = line_add(oldest_r, line_ext_t'(1));
          end else begin
            count_nxt = count_r + line_t'(1);
          end
          if (rows_r >= ROW_W'(SCREEN_ROWS - 1)) begin
            top_nxt = line_add(top_r, line_ext_t'(1));
            refresh = 1'b1;
          end else begin
            rows_nxt = rows_r + ROW_W'(1);
          end
        end
        if (in_data.char_code == NEWLINE_CODE) begin
          wcol_nxt = COL_W'(LINE_WIDTH + 1);
        end else begin
          line_w                = line_add(oldest_nxt, line_ext_t'(count_nxt));
          q_op.kind             = OP_WRITE;
          q_op.addr             = cell_addr(line_w, col_a);
          q_op.wdata            = in_data.char_code;
          q_op.res.draw_valid   = 1'b1;
          q_op.res.draw_row     = rows_nxt;
          q_op.res.draw_column  = col_a;
          q_op.res.draw_char    = in_data.char_code;
          wcol_nxt              = col_a + COL_W'(1);
        end
      end
      CMD_UP: begin
        if (top_r != oldest_r) begin
          top_nxt = line_sub(top_r, line_ext_t'(1));
          if (rows_r < ROW_W'(SCREEN_ROWS - 1)) begin
            rows_nxt = rows_r + ROW_W'(1);
          end
          refresh = 1'b1;
        end
      end
      CMD_DOWN: begin
        if (newest != bottom) begin
          top_nxt = line_add(top_r, line_ext_t'(1));
          refresh = 1'b1;
        end
      end
      CMD_FIRST: begin
        if (top_r != oldest_r) begin
          top_nxt = oldest_r;
          if (count_r < line_t'(SCREEN_ROWS - 1)) begin
            rows_nxt = ROW_W'(count_r);
          end else begin
            rows_nxt = ROW_W'(SCREEN_ROWS - 1);
          end
          refresh = 1'b1;
        end
      end
      CMD_LAST: begin
        if (newest != bottom) begin
          if (count_r < line_t'(SCREEN_ROWS)) begin
            top_nxt = oldest_r;
          end else begin
            top_nxt = line_sub(newest, line_ext_t'(rows_r));
          end
          refresh = 1'b1;
        end
      end
      CMD_READ: begin
        // out-of-window reads return zero without touching the store
        if (in_data.read_row <= rows_r &&
            in_data.read_column <= COL_W'(LINE_WIDTH)) begin
          line_w    = line_add(top_r, line_ext_t'(in_data.read_row));
          q_op.kind = OP_READ;
          q_op.addr = cell_addr(line_w, in_data.read_column);
        end
      end
      default: begin
      end
    endcase
    q_op.res.refresh           = refresh;
    q_op.res.window_first_line = top_nxt;
    q_op.res.window_rows       = rows_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      wcol_r   <= '0;
      top_r    <= '0;
      rows_r   <= '0;
    end else if (accept) begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      wcol_r   <= wcol_nxt;
      top_r    <= top_nxt;
      rows_r   <= rows_nxt;
    end
  end

endmodule

// ===== hw/rtl/tsw_op_fifo.sv =====
// Short queue of classified operations between front and back end.
// Depends on tsw_pkg.
module tsw_op_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tsw_pkg::tsw_op_t push_op,
  output logic             full,
  input  logic             pop,
  output tsw_pkg::tsw_op_t pop_op,
  output logic             empty
);
  import tsw_pkg::*;

  tsw_op_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/tsw_back.sv =====
// Back end: character store, clearing pass after reset, store writes and
// reads, and the output register. Depends on tsw_pkg.
module tsw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  tsw_pkg::tsw_op_t  q_op,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_empty,
  input  logic              out_pop,
  output tsw_pkg::tsw_out_t out_data
);
  import tsw_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_ZERO,
    ST_READ
  } state_t;

  state_t     state_r;
  logic [7:0] mem [STORE_CELLS];
  logic [7:0] rd_data_r;
  addr_t      clr_addr_r;
  addr_t      zaddr_r;
  tsw_out_t   pend_r;
  tsw_out_t   out_r;
  logic       out_valid_r;

  logic       slot_free;
  logic       take;
  logic       we;
  addr_t      waddr;
  logic [7:0] wdata;
  logic       re;
  logic       load_out;
  tsw_out_t   read_res;

  assign clearing  = (state_r == ST_CLEAR);
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_pop;
  assign take      = (state_r == ST_RUN) && !q_empty && slot_free;
  assign q_pop     = take;
  assign re        = take && (q_op.kind == OP_READ);
  // result register loads on a taken non-read op or on read data return
  assign load_out  = (take && (q_op.kind != OP_READ)) || (state_r == ST_READ);

  always_comb begin
    read_res           = pend_r;
    read_res.read_char = rd_data_r;
  end

  always_comb begin
    we    = 1'b0;
    waddr = q_op.addr;
    wdata = q_op.wdata;
    unique case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
        wdata = '0;
      end
      ST_RUN: begin
        we = take && (q_op.kind == OP_WRITE);
      end
      ST_ZERO: begin
        // line terminator after the new character
        we    = 1'b1;
        waddr = zaddr_r;
        wdata = '0;
      end
      ST_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[q_op.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + addr_t'(1);
          if (clr_addr_r == addr_t'(STORE_CELLS - 1)) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (take) begin
            unique case (q_op.kind)
              OP_WRITE: begin
                out_r   <= q_op.res;
                zaddr_r <= q_op.addr + addr_t'(1);
                state_r <= ST_ZERO;
              end
              OP_READ: begin
                pend_r  <= q_op.res;
                state_r <= ST_READ;
              end
              default: begin
                out_r <= q_op.res;
              end
            endcase
          end
        end
        ST_ZERO: begin
          state_r <= ST_RUN;
        end
        ST_READ: begin
          out_r   <= read_res;
          state_r <= ST_RUN;
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/tsw_checker.sv =====
// Port-level checks for the text scrollback window, bound to the top level.
// Depends on tsw_pkg and text_scrollback_window.
module tsw_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input tsw_pkg::tsw_in_t  in_data,
  input logic              in_full,
  input logic              out_pop,
  input tsw_pkg::tsw_out_t out_data,
  input logic              out_empty
);
  import tsw_pkg::*;

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // store sweep blocks input right after reset
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input accepted during store sweep");

  // a draw beat never carries read data
  a_draw_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.draw_valid) |-> (out_data.read_char == 8'd0))
    else $error("draw beat with read data");

  // window height never exceeds the screen
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.window_rows <= 4'(SCREEN_ROWS - 1)))
    else $error("window taller than screen");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed while stalled");

endmodule

bind text_scrollback_window tsw_checker u_tsw_checker (.*);
